// File: hdl/ubx_fb_pkg.sv
// Shared types and constants for the UBX frame builder.
`default_nettype none

package ubx_fb_pkg;

  localparam int unsigned MaxFrameDefault = 512;
  localparam int unsigned FrameOverhead   = 10;
  localparam int unsigned MaxResults      = 8;
  localparam int unsigned CntW            = $clog2(MaxResults + 1);

  localparam logic [7:0] SYNC_1 = 8'hB5;
  localparam logic [7:0] SYNC_2 = 8'h62;

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_PAYLOAD = 1'b1
  } cmd_e;

  typedef logic [CntW-1:0] cnt_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic       rejected;
  } res_t;

  typedef struct packed {
    res_t [MaxResults-1:0] entries;
    cnt_t                  count;
  } res_bundle_t;

endpackage

`default_nettype wire

// File: hdl/ubx_fb_core.sv
// Request register, frame state and single-pass result encoding.
`default_nettype none

module ubx_fb_core #(
  parameter int unsigned MaxFrame = ubx_fb_pkg::MaxFrameDefault
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output      logic                    in_stall_o,
  input  wire logic                    command_i,
  input  wire logic [7:0]              msg_class_i,
  input  wire logic [7:0]              msg_id_i,
  input  wire logic [15:0]             payload_length_i,
  input  wire logic [7:0]              payload_byte_i,
  input  wire logic                    buf_free_i,
  output      logic                    load_o,
  output      ubx_fb_pkg::res_bundle_t res_o
);
  import ubx_fb_pkg::*;

  logic        req_valid_q, req_valid_d;
  logic        cmd_q;
  logic [7:0]  cls_q, id_q, pb_q;
  logic [15:0] len_q;

  logic [7:0]  sum_a_q, sum_a_d, sum_b_q, sum_b_d;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic        frame_open_q, frame_open_d;

  logic        accept, consume, reject;
  logic [7:0]  a1, a2, a3, a4, b2, b3, b4, pa, pbs;
  res_bundle_t res;

  assign reject = (17'(len_q) + 17'(FrameOverhead)) > 17'(MaxFrame);

  always_comb begin
    a1  = cls_q;
    a2  = a1 + id_q;
    b2  = a1 + a2;
    a3  = a2 + len_q[7:0];
    b3  = b2 + a3;
    a4  = a3 + len_q[15:8];
    b4  = b3 + a4;
    pa  = sum_a_q + pb_q;
    pbs = sum_b_q + pa;
  end

  always_comb begin
    res          = '0;
    sum_a_d      = sum_a_q;
    sum_b_d      = sum_b_q;
    bytes_left_d = bytes_left_q;
    frame_open_d = frame_open_q;
    unique case (cmd_e'(cmd_q))
      CMD_START: begin
        frame_open_d = 1'b0;
        bytes_left_d = '0;
        if (reject) begin
          res.entries[0] = '{out_byte: 8'h00, last_byte: 1'b1, rejected: 1'b1};
          res.count      = cnt_t'(1);
        end else begin
          res.entries[0] = '{out_byte: SYNC_1, last_byte: 1'b0, rejected: 1'b0};
          res.entries[1] = '{out_byte: SYNC_2, last_byte: 1'b0, rejected: 1'b0};
          res.entries[2] = '{out_byte: cls_q, last_byte: 1'b0, rejected: 1'b0};
          res.entries[3] = '{out_byte: id_q, last_byte: 1'b0, rejected: 1'b0};
          res.entries[4] = '{out_byte: len_q[7:0], last_byte: 1'b0, rejected: 1'b0};
          res.entries[5] = '{out_byte: len_q[15:8], last_byte: 1'b0, rejected: 1'b0};
          sum_a_d = a4;
          sum_b_d = b4;
          if (len_q == 16'd0) begin
            res.entries[6] = '{out_byte: a4, last_byte: 1'b0, rejected: 1'b0};
            res.entries[7] = '{out_byte: b4, last_byte: 1'b1, rejected: 1'b0};
            res.count      = cnt_t'(8);
          end else begin
            res.count    = cnt_t'(6);
            bytes_left_d = len_q;
            frame_open_d = 1'b1;
          end
        end
      end
      CMD_PAYLOAD: begin
        if (frame_open_q) begin
          res.entries[0] = '{out_byte: pb_q, last_byte: 1'b0, rejected: 1'b0};
          sum_a_d      = pa;
          sum_b_d      = pbs;
          bytes_left_d = bytes_left_q - 16'd1;
          if (bytes_left_q == 16'd1) begin
            res.entries[1] = '{out_byte: pa, last_byte: 1'b0, rejected: 1'b0};
            res.entries[2] = '{out_byte: pbs, last_byte: 1'b1, rejected: 1'b0};
            res.count      = cnt_t'(3);
            frame_open_d   = 1'b0;
            bytes_left_d   = '0;
          end else begin
            res.count = cnt_t'(1);
          end
        end
      end
      default: res = '0;
    endcase
  end

  assign consume    = req_valid_q && ((res.count == '0) || buf_free_i);
  assign load_o     = req_valid_q && (res.count != '0) && buf_free_i;
  assign res_o      = res;
  assign in_stall_o = req_valid_q && !consume;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    req_valid_d = req_valid_q;
    if (accept) begin
      req_valid_d = 1'b1;
    end else if (consume) begin
      req_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q  <= 1'b0;
      sum_a_q      <= '0;
      sum_b_q      <= '0;
      bytes_left_q <= '0;
      frame_open_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      if (consume) begin
        sum_a_q      <= sum_a_d;
        sum_b_q      <= sum_b_d;
        bytes_left_q <= bytes_left_d;
        frame_open_q <= frame_open_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      cls_q <= msg_class_i;
      id_q  <= msg_id_i;
      len_q <= payload_length_i;
      pb_q  <= payload_byte_i;
    end
  end

  a_open_has_bytes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_open_q |-> (bytes_left_q != 16'd0))
    else $error("open frame with no payload bytes left");

  a_closed_no_bytes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !frame_open_q |-> (bytes_left_q == 16'd0))
    else $error("closed frame with payload bytes left");

  a_reject_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && (cmd_q == CMD_START) && reject) |=> !frame_open_q)
    else $error("rejected start left a frame open");

endmodule

`default_nettype wire

// File: hdl/ubx_fb_outbuf.sv
// Result buffer that delivers the bytes of one request one per cycle unless stalled.
`default_nettype none

module ubx_fb_outbuf (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    load_i,
  input  wire ubx_fb_pkg::res_bundle_t res_i,
  output      logic                    buf_free_o,
  output      logic                    out_valid_o,
  input  wire logic                    out_stall_i,
  output      logic [7:0]              out_byte_o,
  output      logic                    last_byte_o,
  output      logic                    rejected_o
);
  import ubx_fb_pkg::*;

  res_t [MaxResults-1:0] entries_q;
  cnt_t                  count_q, count_d;
  logic                  out_take;

  assign out_valid_o = count_q != '0;
  assign out_take    = out_valid_o && !out_stall_i;
  assign buf_free_o  = (count_q == '0) || (out_take && (count_q == cnt_t'(1)));
  assign out_byte_o  = entries_q[0].out_byte;
  assign last_byte_o = entries_q[0].last_byte;
  assign rejected_o  = entries_q[0].rejected;

  always_comb begin
    count_d = count_q;
    if (load_i) begin
      count_d = res_i.count;
    end else if (out_take) begin
      count_d = count_q - cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      entries_q <= res_i.entries;
    end else if (out_take) begin
      for (int k = 0; k < MaxResults - 1; k++) begin
        entries_q[k] <= entries_q[k+1];
      end
    end
  end

  a_reject_alone : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rejected_o) |-> (last_byte_o && (count_q == cnt_t'(1))))
    else $error("rejection result is not a lone final result");

  a_load_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (count_q != '0))
    else $error("load left the buffer empty");

  a_drain_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && (count_q == cnt_t'(1)) && !load_i) |=> (count_q == '0))
    else $error("buffer did not empty after its final result");

endmodule

`default_nettype wire

// File: hdl/ubx_frame_builder.sv
// UBX frame builder top level: request register, encoder and result buffer.
// Each request is registered, encoded in one pass and loaded whole into an
// eight-entry result buffer that hands out one byte per cycle on the output
// port while the output is not stalled. A payload request yields one byte
// (three on the last payload byte, which adds the two checksum bytes), so
// payload bytes stream at one per cycle when the output is not stalled. A
// start request yields six header bytes, eight when the length is zero, or
// one rejection result when length plus ten exceeds MaxFrame; the output
// port's one byte per cycle sets how long it occupies the buffer, and the
// next request is taken while the last byte of the previous one leaves. A
// payload request with no open frame yields nothing and is consumed unloaded.
`default_nettype none

module ubx_frame_builder #(
  parameter int unsigned MaxFrame = ubx_fb_pkg::MaxFrameDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic        command_i,
  input  wire logic [7:0]  msg_class_i,
  input  wire logic [7:0]  msg_id_i,
  input  wire logic [15:0] payload_length_i,
  input  wire logic [7:0]  payload_byte_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [7:0]  out_byte_o,
  output      logic        last_byte_o,
  output      logic        rejected_o
);
  import ubx_fb_pkg::*;

  logic        buf_free, load;
  res_bundle_t res;

  ubx_fb_core #(
    .MaxFrame(MaxFrame)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .msg_class_i     (msg_class_i),
    .msg_id_i        (msg_id_i),
    .payload_length_i(payload_length_i),
    .payload_byte_i  (payload_byte_i),
    .buf_free_i      (buf_free),
    .load_o          (load),
    .res_o           (res)
  );

  ubx_fb_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .res_i      (res),
    .buf_free_o (buf_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .last_byte_o(last_byte_o),
    .rejected_o (rejected_o)
  );

endmodule

`default_nettype wire
